[sv/lzsd_pkg.sv]
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants of the LZSS stream decoder: front-end phases,
// command format of the front-to-back queue, error and register codes.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  localparam int SIZE_W   = 32;
  localparam int OFF_W    = 12;
  localparam int LEN_W    = 4;
  localparam int CNT_W    = 5;
  localparam int FLAG_W   = 4;
  localparam int CQ_DEPTH = 2;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_BADREF = 2'd1;
  localparam logic [1:0] ERR_SHORT  = 2'd2;

  localparam logic REG_FLAG_MODE = 1'b0;
  localparam logic REG_MIN_LEN   = 1'b1;

  localparam logic [4:0] MIN_LEN_LO    = 5'd1;
  localparam logic [4:0] MIN_LEN_HI    = 5'd16;
  localparam logic [4:0] MIN_LEN_RESET = 5'd3;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FLAG,
    PH_LIT,
    PH_TOKHI,
    PH_TOKLO,
    PH_RUNLIT,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_STAT
  } cmd_kind_t;

  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_RAM,
    SRC_LAST
  } src_sel_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [7:0]             data;
    logic [OFF_W-1:0]       offset;
    logic [CNT_W-1:0]       count;
    logic                   done;
    logic [1:0]             err;
  } cmd_t;

endpackage

[sv/lzsd_ram.sv]
// ----------------------------------------------------------------------------
// lzsd_ram
// Generic single-write, single-read RAM with registered, enabled read port.
// ----------------------------------------------------------------------------
module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/lzsd_front.sv]
// ----------------------------------------------------------------------------
// lzsd_front
// Parses the compressed byte stream (header, flag bytes, tokens, literals),
// tracks output size and window fill, and issues one command per beat that
// produces results.
// ----------------------------------------------------------------------------
module lzsd_front #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                in_stall,
  input  logic                flag_mode,
  input  logic [4:0]          min_len,
  input  logic                cmd_full,
  output logic                cmd_valid,
  output lzsd_pkg::cmd_t      cmd
);

  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int CW = lzsd_pkg::OFF_W + 2;

  lzsd_pkg::phase_t               phase_r, phase_nxt;
  logic [1:0]                     hdr_cnt_r, hdr_cnt_nxt;
  logic [lzsd_pkg::SIZE_W-1:0]    exp_r, exp_nxt;
  logic [lzsd_pkg::SIZE_W-1:0]    rem_r, rem_nxt;
  logic [FW-1:0]                  fill_r, fill_nxt;
  logic [7:0]                     fbits_r, fbits_nxt;
  logic [lzsd_pkg::FLAG_W-1:0]    fidx_r, fidx_nxt;
  logic [7:0]                     tokhi_r, tokhi_nxt;
  logic [lzsd_pkg::LEN_W-1:0]     litleft_r, litleft_nxt;

  logic                           acc;
  logic                           emit;
  logic                           done_now;
  logic [lzsd_pkg::CNT_W-1:0]     emit_n;
  logic [1:0]                     err;
  logic [lzsd_pkg::OFF_W-1:0]     offset;
  logic [lzsd_pkg::CNT_W-1:0]     len;
  logic [CW-1:0]                  fill_sum;
  logic [lzsd_pkg::LEN_W-1:0]     litleft_dec;

  function automatic lzsd_pkg::phase_t next_item(input logic [lzsd_pkg::FLAG_W-1:0] idx,
                                                 input logic [7:0] bits);
    lzsd_pkg::phase_t ph;
    if (idx >= lzsd_pkg::FLAG_W'(8)) begin
      ph = lzsd_pkg::PH_FLAG;
    end else if (bits[idx[2:0]]) begin
      ph = lzsd_pkg::PH_LIT;
    end else begin
      ph = lzsd_pkg::PH_TOKHI;
    end
    return ph;
  endfunction

  assign acc      = in_valid && !cmd_full;
  assign in_stall = cmd_full;
  assign offset   = {tokhi_r, in_byte[7:4]};
  assign len      = lzsd_pkg::CNT_W'(in_byte[3:0]) + min_len;
  assign litleft_dec = litleft_r - lzsd_pkg::LEN_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    exp_nxt     = exp_r;
    rem_nxt     = rem_r;
    fill_nxt    = fill_r;
    fbits_nxt   = fbits_r;
    fidx_nxt    = fidx_r;
    tokhi_nxt   = tokhi_r;
    litleft_nxt = litleft_r;
    emit        = 1'b0;
    emit_n      = '0;
    done_now    = 1'b0;
    err         = lzsd_pkg::ERR_NONE;
    fill_sum    = '0;
    cmd         = '0;
    cmd.kind    = lzsd_pkg::CMD_STAT;
    cmd_valid   = 1'b0;

    if (acc) begin
      unique case (phase_r)
        lzsd_pkg::PH_HEADER: begin
          exp_nxt     = {exp_r[23:0], in_byte};
          hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          if (hdr_cnt_r == 2'd3) begin
            fill_nxt = '0;
            fidx_nxt = lzsd_pkg::FLAG_W'(8);
            rem_nxt  = exp_nxt;
            if (exp_nxt == '0) begin
              phase_nxt = lzsd_pkg::PH_DONE;
              done_now  = 1'b1;
            end else if (flag_mode) begin
              phase_nxt = lzsd_pkg::PH_FLAG;
            end else begin
              phase_nxt = lzsd_pkg::PH_TOKHI;
            end
          end
        end
        lzsd_pkg::PH_FLAG: begin
          fbits_nxt = in_byte;
          fidx_nxt  = '0;
          phase_nxt = next_item('0, in_byte);
        end
        lzsd_pkg::PH_LIT, lzsd_pkg::PH_RUNLIT: begin
          emit      = 1'b1;
          emit_n    = lzsd_pkg::CNT_W'(1);
          cmd.kind  = lzsd_pkg::CMD_LIT;
          cmd.data  = in_byte;
          cmd.count = lzsd_pkg::CNT_W'(1);
          if (rem_r == lzsd_pkg::SIZE_W'(1)) begin
            cmd.done  = 1'b1;
            phase_nxt = lzsd_pkg::PH_DONE;
          end else if (phase_r == lzsd_pkg::PH_RUNLIT) begin
            if (litleft_dec == '0) begin
              phase_nxt = lzsd_pkg::PH_TOKHI;
            end
          end else if (flag_mode) begin
            fidx_nxt  = fidx_r + lzsd_pkg::FLAG_W'(1);
            phase_nxt = next_item(fidx_nxt, fbits_r);
          end else begin
            phase_nxt = lzsd_pkg::PH_TOKHI;
          end
          if (phase_r == lzsd_pkg::PH_RUNLIT) begin
            litleft_nxt = litleft_dec;
          end
        end
        lzsd_pkg::PH_TOKHI: begin
          tokhi_nxt = in_byte;
          phase_nxt = lzsd_pkg::PH_TOKLO;
        end
        lzsd_pkg::PH_TOKLO: begin
          if (offset == '0 && !flag_mode) begin
            litleft_nxt = in_byte[3:0];
            phase_nxt   = (in_byte[3:0] != '0) ? lzsd_pkg::PH_RUNLIT : lzsd_pkg::PH_TOKHI;
          end else if (offset == '0 || CW'(offset) > CW'(fill_r)) begin
            err       = lzsd_pkg::ERR_BADREF;
            phase_nxt = lzsd_pkg::PH_ERROR;
          end else begin
            emit       = 1'b1;
            cmd.kind   = lzsd_pkg::CMD_COPY;
            cmd.offset = offset;
            if (lzsd_pkg::SIZE_W'(len) >= rem_r) begin
              emit_n    = rem_r[lzsd_pkg::CNT_W-1:0];
              cmd.done  = 1'b1;
              phase_nxt = lzsd_pkg::PH_DONE;
            end else begin
              emit_n = len;
              if (flag_mode) begin
                fidx_nxt  = fidx_r + lzsd_pkg::FLAG_W'(1);
                phase_nxt = next_item(fidx_nxt, fbits_r);
              end else begin
                phase_nxt = lzsd_pkg::PH_TOKHI;
              end
            end
            cmd.count = emit_n;
          end
        end
        lzsd_pkg::PH_DONE, lzsd_pkg::PH_ERROR: begin
        end
        default: begin
        end
      endcase

      if (emit) begin
        rem_nxt  = rem_r - lzsd_pkg::SIZE_W'(emit_n);
        fill_sum = CW'(fill_r) + CW'(emit_n);
        if (fill_sum > CW'(WINDOW_DEPTH)) begin
          fill_nxt = FW'(WINDOW_DEPTH);
        end else begin
          fill_nxt = fill_sum[FW-1:0];
        end
      end

      if (in_last) begin
        if (err == lzsd_pkg::ERR_NONE && phase_nxt != lzsd_pkg::PH_DONE &&
            phase_nxt != lzsd_pkg::PH_ERROR) begin
          err = lzsd_pkg::ERR_SHORT;
        end
        phase_nxt   = lzsd_pkg::PH_HEADER;
        hdr_cnt_nxt = '0;
        exp_nxt     = '0;
        rem_nxt     = '0;
        fill_nxt    = '0;
        fbits_nxt   = '0;
        fidx_nxt    = lzsd_pkg::FLAG_W'(8);
        tokhi_nxt   = '0;
        litleft_nxt = '0;
      end

      cmd.err   = err;
      if (done_now) begin
        cmd.done = 1'b1;
      end
      cmd_valid = emit || (err != lzsd_pkg::ERR_NONE) || done_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lzsd_pkg::PH_HEADER;
      hdr_cnt_r <= '0;
      exp_r     <= '0;
      rem_r     <= '0;
      fill_r    <= '0;
      fbits_r   <= '0;
      fidx_r    <= lzsd_pkg::FLAG_W'(8);
      tokhi_r   <= '0;
      litleft_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      exp_r     <= exp_nxt;
      rem_r     <= rem_nxt;
      fill_r    <= fill_nxt;
      fbits_r   <= fbits_nxt;
      fidx_r    <= fidx_nxt;
      tokhi_r   <= tokhi_nxt;
      litleft_r <= litleft_nxt;
    end
  end

endmodule

[sv/lzsd_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// lzsd_cmd_fifo
// Short register queue of decode commands between front and back end.
// ----------------------------------------------------------------------------
module lzsd_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  lzsd_pkg::cmd_t  wr_data,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output lzsd_pkg::cmd_t  rd_data
);

  localparam int PW = $clog2(lzsd_pkg::CQ_DEPTH);
  localparam int NW = $clog2(lzsd_pkg::CQ_DEPTH + 1);

  lzsd_pkg::cmd_t  q_r [lzsd_pkg::CQ_DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic            do_wr;
  logic            do_rd;

  assign full     = (cnt_r == NW'(lzsd_pkg::CQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = q_r[rptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PW'(lzsd_pkg::CQ_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PW'(lzsd_pkg::CQ_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[sv/lzsd_back.sv]
// ----------------------------------------------------------------------------
// lzsd_back
// Executes decode commands: literals and status beats pass straight through,
// back-reference copies read the history window one byte per cycle unless
// the output stalls. Every emitted byte is written back into the window.
// Output is a registered beat.
module lzsd_back #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  input  lzsd_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_run_end,
  output logic            out_stream_done,
  output logic [1:0]      out_error_code
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = lzsd_pkg::OFF_W + 2;

  // copy sequencer
  logic                       cp_act_r, cp_act_nxt;
  logic [lzsd_pkg::CNT_W-1:0] cp_cnt_r, cp_cnt_nxt;
  logic [AW-1:0]              cp_src_r, cp_src_nxt;
  logic                       cp_off1_r, cp_off1_nxt;
  logic                       cp_done_r, cp_done_nxt;
  logic [1:0]                 cp_err_r, cp_err_nxt;

  // data stage
  logic                       b_vld_r, b_vld_nxt;
  lzsd_pkg::src_sel_t         b_sel_r, b_sel_nxt;
  logic [7:0]                 b_lit_r, b_lit_nxt;
  logic                       b_bv_r, b_bv_nxt;
  logic                       b_last_r, b_last_nxt;
  logic                       b_done_r, b_done_nxt;
  logic [1:0]                 b_err_r, b_err_nxt;

  // output register
  logic                       o_vld_r, o_vld_nxt;
  logic [7:0]                 o_byte_r, o_byte_nxt;
  logic                       o_bv_r, o_bv_nxt;
  logic                       o_last_r, o_last_nxt;
  logic                       o_done_r, o_done_nxt;
  logic [1:0]                 o_err_r, o_err_nxt;

  logic [AW-1:0]              wp_r, wp_nxt;
  logic [7:0]                 lastw_r, lastw_nxt;

  logic                       o_free;
  logic                       b_move;
  logic                       b_free;
  logic                       issue;
  logic [7:0]                 b_data;
  logic [7:0]                 ram_q;
  logic                       ram_we;
  logic [CW-1:0]              pos;
  logic [CW-1:0]              off_ext;
  logic [CW-1:0]              src_diff;
  logic [AW-1:0]              src0;

  assign o_free  = !o_vld_r || !out_stall;
  assign b_move  = b_vld_r && o_free;
  assign b_free  = !b_vld_r || o_free;
  assign cmd_pop = cmd_valid && !cp_act_r && b_free;
  assign issue   = cp_act_r && b_free;
  assign ram_we  = b_move && b_bv_r;

  always_comb begin
    unique case (b_sel_r)
      lzsd_pkg::SRC_RAM:  b_data = ram_q;
      lzsd_pkg::SRC_LAST: b_data = lastw_r;
      default:            b_data = b_lit_r;
    endcase
  end

  // first source slot: write position of the first copied byte minus offset
  always_comb begin
    pos     = CW'(wp_r) + CW'(b_vld_r && b_bv_r);
    off_ext = CW'(cmd.offset);
    if (pos >= off_ext) begin
      src_diff = pos - off_ext;
    end else begin
      src_diff = pos + CW'(WINDOW_DEPTH) - off_ext;
    end
    src0 = src_diff[AW-1:0];
  end

  always_comb begin
    cp_act_nxt  = cp_act_r;
    cp_cnt_nxt  = cp_cnt_r;
    cp_src_nxt  = cp_src_r;
    cp_off1_nxt = cp_off1_r;
    cp_done_nxt = cp_done_r;
    cp_err_nxt  = cp_err_r;
    b_vld_nxt   = b_vld_r && !b_move;
    b_sel_nxt   = b_sel_r;
    b_lit_nxt   = b_lit_r;
    b_bv_nxt    = b_bv_r;
    b_last_nxt  = b_last_r;
    b_done_nxt  = b_done_r;
    b_err_nxt   = b_err_r;

    if (cmd_pop) begin
      unique case (cmd.kind)
        lzsd_pkg::CMD_COPY: begin
          cp_act_nxt  = 1'b1;
          cp_cnt_nxt  = cmd.count;
          cp_src_nxt  = src0;
          cp_off1_nxt = (cmd.offset == lzsd_pkg::OFF_W'(1));
          cp_done_nxt = cmd.done;
          cp_err_nxt  = cmd.err;
        end
        lzsd_pkg::CMD_LIT: begin
          b_vld_nxt  = 1'b1;
          b_sel_nxt  = lzsd_pkg::SRC_LIT;
          b_lit_nxt  = cmd.data;
          b_bv_nxt   = 1'b1;
          b_last_nxt = 1'b1;
          b_done_nxt = cmd.done;
          b_err_nxt  = cmd.err;
        end
        default: begin
          b_vld_nxt  = 1'b1;
          b_sel_nxt  = lzsd_pkg::SRC_LIT;
          b_lit_nxt  = '0;
          b_bv_nxt   = 1'b0;
          b_last_nxt = 1'b1;
          b_done_nxt = cmd.done;
          b_err_nxt  = cmd.err;
        end
      endcase
    end else if (issue) begin
      b_vld_nxt  = 1'b1;
      b_sel_nxt  = cp_off1_r ? lzsd_pkg::SRC_LAST : lzsd_pkg::SRC_RAM;
      b_bv_nxt   = 1'b1;
      b_last_nxt = (cp_cnt_r == lzsd_pkg::CNT_W'(1));
      b_done_nxt = (cp_cnt_r == lzsd_pkg::CNT_W'(1)) && cp_done_r;
      b_err_nxt  = (cp_cnt_r == lzsd_pkg::CNT_W'(1)) ? cp_err_r : lzsd_pkg::ERR_NONE;
      cp_cnt_nxt = cp_cnt_r - lzsd_pkg::CNT_W'(1);
      cp_src_nxt = (cp_src_r == AW'(WINDOW_DEPTH - 1)) ? '0 : cp_src_r + AW'(1);
      if (cp_cnt_r == lzsd_pkg::CNT_W'(1)) begin
        cp_act_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    wp_nxt     = wp_r;
    lastw_nxt  = lastw_r;
    o_vld_nxt  = o_vld_r && !o_free;
    o_byte_nxt = o_byte_r;
    o_bv_nxt   = o_bv_r;
    o_last_nxt = o_last_r;
    o_done_nxt = o_done_r;
    o_err_nxt  = o_err_r;
    if (ram_we) begin
      wp_nxt    = (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      lastw_nxt = b_data;
    end
    if (b_move) begin
      o_vld_nxt  = 1'b1;
      o_byte_nxt = b_bv_r ? b_data : 8'd0;
      o_bv_nxt   = b_bv_r;
      o_last_nxt = b_last_r;
      o_done_nxt = b_done_r;
      o_err_nxt  = b_err_r;
    end
  end

  lzsd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (b_data),
    .re    (issue),
    .raddr (cp_src_r),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    cp_cnt_r  <= cp_cnt_nxt;
    cp_src_r  <= cp_src_nxt;
    cp_off1_r <= cp_off1_nxt;
    cp_done_r <= cp_done_nxt;
    cp_err_r  <= cp_err_nxt;
    b_sel_r   <= b_sel_nxt;
    b_lit_r   <= b_lit_nxt;
    b_bv_r    <= b_bv_nxt;
    b_last_r  <= b_last_nxt;
    b_done_r  <= b_done_nxt;
    b_err_r   <= b_err_nxt;
    o_byte_r  <= o_byte_nxt;
    o_bv_r    <= o_bv_nxt;
    o_last_r  <= o_last_nxt;
    o_done_r  <= o_done_nxt;
    o_err_r   <= o_err_nxt;
    lastw_r   <= lastw_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_act_r <= 1'b0;
      b_vld_r  <= 1'b0;
      o_vld_r  <= 1'b0;
      wp_r     <= '0;
    end else begin
      cp_act_r <= cp_act_nxt;
      b_vld_r  <= b_vld_nxt;
      o_vld_r  <= o_vld_nxt;
      wp_r     <= wp_nxt;
    end
  end

  assign out_valid       = o_vld_r;
  assign out_byte        = o_byte_r;
  assign out_byte_valid  = o_bv_r;
  assign out_run_end     = o_last_r;
  assign out_stream_done = o_done_r;
  assign out_error_code  = o_err_r;

endmodule

[sv/lzss_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// lzss_stream_decoder_core
// LZSS decompressor, 12-bit back-offset / 4-bit length tokens.
//
// Input channel (in_valid/in_stall): one compressed byte per beat, header
// first (4-byte big-endian size), in_last on the final byte of a stream.
// Output channel (out_valid/out_stall): one decoded byte per beat, with
// run_end on the last beat caused by an input byte, stream_done when the
// original size is reached, and error_code on that last beat.
// Config port (APB): 0x0 flag_mode, 0x4 min_len (saturated 1..16).
// The front end parses header, flag and token bytes, and copies are paced
// by the single read port of the history RAM. A command queue of two lets
// the front keep parsing while the back end copies. An accepted byte
// reaches the output through the command queue, the data stage and the
// output register; a copy first passes the copy sequencer.
// Reset: registers return to flag mode with minimum length 3, the decoder
// waits for a header; the history RAM is not cleared. A stalled output holds
// its beat, and the queue fills until in_stall rises.
// ----------------------------------------------------------------------------
module lzss_stream_decoder_core #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_run_end,
  output logic        out_stream_done,
  output logic [1:0]  out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                 flag_mode_r, flag_mode_nxt;
  logic [4:0]           min_len_r, min_len_nxt;
  logic                 cfg_wr;
  logic                 f_cmd_valid;
  lzsd_pkg::cmd_t       f_cmd;
  logic                 q_full;
  logic                 q_valid;
  lzsd_pkg::cmd_t       q_cmd;
  logic                 q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    flag_mode_nxt = flag_mode_r;
    min_len_nxt   = min_len_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        lzsd_pkg::REG_FLAG_MODE: flag_mode_nxt = pwdata[0];
        default: begin
          if (pwdata[4:0] < lzsd_pkg::MIN_LEN_LO) begin
            min_len_nxt = lzsd_pkg::MIN_LEN_LO;
          end else if (pwdata[4:0] > lzsd_pkg::MIN_LEN_HI) begin
            min_len_nxt = lzsd_pkg::MIN_LEN_HI;
          end else begin
            min_len_nxt = pwdata[4:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lzsd_pkg::REG_FLAG_MODE: prdata = {31'd0, flag_mode_r};
      default:                 prdata = {27'd0, min_len_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_mode_r <= 1'b1;
      min_len_r   <= lzsd_pkg::MIN_LEN_RESET;
    end else begin
      flag_mode_r <= flag_mode_nxt;
      min_len_r   <= min_len_nxt;
    end
  end

  lzsd_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .flag_mode (flag_mode_r),
    .min_len   (min_len_r),
    .cmd_full  (q_full),
    .cmd_valid (f_cmd_valid),
    .cmd       (f_cmd)
  );

  lzsd_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (f_cmd_valid),
    .wr_data  (f_cmd),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_cmd)
  );

  lzsd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_valid),
    .cmd             (q_cmd),
    .cmd_pop         (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_run_end     (out_run_end),
    .out_stream_done (out_stream_done),
    .out_error_code  (out_error_code)
  );

endmodule

[sv/lzsd_checker.sv]
// ----------------------------------------------------------------------------
// lzsd_checker
// Port-level checks of the decoder output beats, bound to the top level.
// ----------------------------------------------------------------------------
module lzsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_run_end,
  input logic       out_stream_done,
  input logic [1:0] out_error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_error_code) && $stable(out_run_end))
    else $error("output beat changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'd0)
    else $error("status beat carries nonzero data");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code <= lzsd_pkg::ERR_SHORT)
    else $error("undefined error code");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != lzsd_pkg::ERR_NONE || out_stream_done) |-> out_run_end)
    else $error("error or completion not on the last beat of a byte");

  a_status_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_stream_done || out_error_code != lzsd_pkg::ERR_NONE)
    else $error("empty beat without completion or error");

endmodule

bind lzss_stream_decoder_core lzsd_checker u_lzsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_byte_valid  (out_byte_valid),
  .out_run_end     (out_run_end),
  .out_stream_done (out_stream_done),
  .out_error_code  (out_error_code)
);
